FILE: rtl/assert_macros.svh
// Assertion macros shared by the decoder RTL.
// Needs signals clk and arst_n in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked property, ignored while reset is asserted.
`define GLD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked property, evaluated during reset as well.
`define GLD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/gld_pkg.sv
// Package of the GIF LZW decoder: dictionary entry type, operation codes,
// bit unpacker status and the root size clamp. No dependencies.
package gld_pkg;

	localparam int TABLE_DEPTH_DEF    = 4096;
	localparam int MAX_CODE_WIDTH_DEF = 12;
	localparam int CODE_W             = 12;
	localparam logic [3:0] ROOT_SIZE_RST = 4'd8;

	typedef struct packed {
		logic [CODE_W-1:0] parent;
		logic [CODE_W-1:0] length;
		logic [7:0]        first;
		logic [7:0]        last;
	} entry_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_WALK,
		OP_KNOWN
	} op_t;

	typedef struct packed {
		logic [CODE_W-1:0] acc;
		logic [3:0]        gathered;
		logic [7:0]        held;
		logic [3:0]        held_left;
		logic              done;
	} unpack_t;

	// Bring a written root size into the range the table and code width allow.
	function automatic logic [3:0] clamp_root(logic [3:0] v, int mcw, int depth);
		logic [3:0] r;
		r = v;
		if (r < 4'd2) r = 4'd2;
		if (r > 4'd11) r = 4'd11;
		for (int i = 0; i < 9; i++) begin
			if (r > 4'd2 && ((int'(r) + 1 > mcw) || ((1 << r) + 2 > depth))) begin
				r = r - 4'd1;
			end
		end
		return r;
	endfunction

endpackage

FILE: rtl/gld_if.sv
// Valid/ready channel interfaces for decoder requests and results.
// Standalone; no package needed.
interface gld_req_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] data_byte;
	modport source (output valid, req_type, data_byte, input ready);
	modport sink (input valid, req_type, data_byte, output ready);
endinterface

interface gld_res_if;
	logic        valid;
	logic        ready;
	logic        pixel_valid;
	logic [7:0]  color_index;
	logic [31:0] pixel_number;
	logic        need_byte;
	logic        end_of_image;
	logic        decode_error;
	modport source (output valid, pixel_valid, color_index, pixel_number, need_byte,
		end_of_image, decode_error, input ready);
	modport sink (input valid, pixel_valid, color_index, pixel_number, need_byte,
		end_of_image, decode_error, output ready);
endinterface

FILE: rtl/gld_unpack.sv
// Bit gatherer: moves up to one code's worth of held bits, LSB first,
// into the code accumulator. Depends on gld_pkg.
module gld_unpack (
	input  logic [gld_pkg::CODE_W-1:0] acc,
	input  logic [3:0]                 gathered,
	input  logic [3:0]                 code_width,
	input  logic [7:0]                 held,
	input  logic [3:0]                 held_left,
	output gld_pkg::unpack_t           result
);
	import gld_pkg::*;

	logic [3:0] want;
	logic [3:0] n;
	logic [8:0] mask;
	logic [7:0] bits;

	always_comb begin
		want = code_width - gathered;
		n = (held_left < want) ? held_left : want;
		mask = (9'd1 << n) - 9'd1;
		bits = held & mask[7:0];
		result.acc = acc | (CODE_W'(bits) << gathered);
		result.held = held >> n;
		result.held_left = held_left - n;
		result.gathered = gathered + n;
		result.done = (gathered + n) >= code_width;
	end

endmodule

FILE: rtl/gld_table.sv
// Dictionary memory: separate write and read addresses, registered read.
// Root codes are not stored; they read as their fixed entries. Uses gld_pkg.
module gld_table #(
	parameter int TABLE_DEPTH = gld_pkg::TABLE_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [gld_pkg::CODE_W-1:0] waddr,
	input  gld_pkg::entry_t            wdata,
	input  logic                       re,
	input  logic [gld_pkg::CODE_W-1:0] raddr,
	input  logic [gld_pkg::CODE_W:0]   roots,
	output gld_pkg::entry_t            rdata
);
	import gld_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);

	entry_t            mem [TABLE_DEPTH];
	entry_t            mem_q;
	logic [CODE_W-1:0] raddr_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr[AW-1:0]] <= wdata;
		end
		if (re) begin
			mem_q <= mem[raddr[AW-1:0]];
			raddr_q <= raddr;
		end
	end

	always_comb begin
		if ({1'b0, raddr_q} < roots) begin
			rdata.parent = '0;
			rdata.length = CODE_W'(1);
			rdata.first = raddr_q[7:0];
			rdata.last = raddr_q[7:0];
		end else begin
			rdata = mem_q;
		end
	end

endmodule

FILE: rtl/gld_lzw_decoder_core.sv
// GIF LZW decoder core. Each request transfer is handled in two steps: the
// first gathers code bits and issues at most one dictionary access, the
// second takes the registered read data, writes back a new entry for a
// known code and loads the result register. No new request is taken while
// the second step runs. A result register holds the result for the result
// channel; a new request is taken only when it is empty or being read.
// Writing root_code_size restarts decoding; no clearing pass is needed.
`include "assert_macros.svh"

module gif_lzw_decoder_core #(
	parameter int TABLE_DEPTH    = gld_pkg::TABLE_DEPTH_DEF,
	parameter int MAX_CODE_WIDTH = gld_pkg::MAX_CODE_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [3:0] cfg_wdata,
	gld_req_if.sink    req_ch,
	gld_res_if.source  res_ch
);
	import gld_pkg::*;

	localparam logic [CODE_W:0] DEPTH_C = (CODE_W+1)'(TABLE_DEPTH);
	localparam logic [3:0]      MCW_C   = 4'(MAX_CODE_WIDTH);

	// Decoder state.
	logic [3:0]        rs_q, rs_d;
	logic [CODE_W-1:0] acc_q, acc_d;
	logic [3:0]        gath_q, gath_d;
	logic [3:0]        cw_q, cw_d;
	logic [CODE_W:0]   nfc_q, nfc_d;
	logic [CODE_W-1:0] prev_q, prev_d;
	logic [CODE_W-1:0] prev_len_q, prev_len_d;
	logic [7:0]        prev_first_q, prev_first_d;
	logic              fac_q, fac_d;
	logic [7:0]        held_q, held_d;
	logic [3:0]        left_q, left_d;
	logic [CODE_W-1:0] wptr_q, wptr_d;
	logic [CODE_W-1:0] woff_q, woff_d;
	logic              wact_q, wact_d;
	logic [31:0]       pcnt_q, pcnt_d;
	logic              end_q, end_d;
	logic              err_q, err_d;

	// Second-step stage.
	logic              busy_s1;
	op_t               op_s1, op_d;
	logic              pull_s1, pull_d;
	logic [CODE_W-1:0] code_s1;

	// Result register.
	logic        res_valid_q;
	logic        pv_q, pv_d;
	logic [7:0]  color_q, color_d;
	logic [31:0] pnum_q, pnum_d;
	logic        need_q, need_d;

	logic              acc_ok;
	logic              active;
	logic [CODE_W:0]   roots;
	logic [CODE_W:0]   code_x;
	logic [CODE_W-1:0] code;
	unpack_t           unp;
	entry_t            rd;

	// Memory access.
	logic              tbl_we, tbl_re;
	logic [CODE_W-1:0] tbl_raddr;
	entry_t            tbl_wdata;

	// Shared entry add.
	logic              ae_do;
	logic [CODE_W-1:0] ae_parent;
	logic [CODE_W-1:0] ae_len;
	logic [7:0]        ae_first;
	logic [7:0]        ae_last;
	logic [CODE_W:0]   cw_limit;

	logic [3:0] rs_new;

	function automatic logic [CODE_W-1:0] slot(logic [CODE_W-1:0] c);
		return ({1'b0, c} < DEPTH_C) ? c : '0;
	endfunction

	assign acc_ok = req_ch.valid && req_ch.ready;
	assign req_ch.ready = !busy_s1 && (!res_valid_q || res_ch.ready);
	assign active = !end_q && !err_q;
	assign roots = (CODE_W+1)'(1) << rs_q;
	assign code = unp.acc;
	assign code_x = {1'b0, unp.acc};
	assign rs_new = clamp_root(cfg_wdata, MAX_CODE_WIDTH, TABLE_DEPTH);

	gld_unpack u_unpack (
		.acc       (acc_q),
		.gathered  (gath_q),
		.code_width(cw_q),
		.held      (held_q),
		.held_left (left_q),
		.result    (unp)
	);

	gld_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_table (
		.clk  (clk),
		.we   (tbl_we),
		.waddr(nfc_q[CODE_W-1:0]),
		.wdata(tbl_wdata),
		.re   (tbl_re),
		.raddr(tbl_raddr),
		.roots(roots),
		.rdata(rd)
	);

	always_comb begin
		rs_d = rs_q; acc_d = acc_q; gath_d = gath_q; cw_d = cw_q; nfc_d = nfc_q;
		prev_d = prev_q; prev_len_d = prev_len_q; prev_first_d = prev_first_q;
		fac_d = fac_q; held_d = held_q; left_d = left_q; wptr_d = wptr_q;
		woff_d = woff_q; wact_d = wact_q; pcnt_d = pcnt_q; end_d = end_q; err_d = err_q;
		op_d = OP_NONE; pull_d = 1'b0;
		pv_d = 1'b0; color_d = '0; pnum_d = '0; need_d = 1'b0;
		tbl_re = 1'b0; tbl_raddr = wptr_q;
		ae_do = 1'b0; ae_parent = slot(prev_q);
		ae_len = prev_len_q + CODE_W'(1); ae_first = prev_first_q; ae_last = prev_first_q;

		if (acc_ok) begin
			pull_d = req_ch.req_type && active;
			if (active) begin
				if (!req_ch.req_type) begin
					held_d = req_ch.data_byte;
					left_d = 4'd8;
				end else if (wact_q) begin
					op_d = OP_WALK;
					tbl_re = 1'b1;
					tbl_raddr = wptr_q;
				end else if (left_q != 4'd0) begin
					acc_d = unp.acc; gath_d = unp.gathered;
					held_d = unp.held; left_d = unp.held_left;
					if (unp.done) begin
						acc_d = '0;
						gath_d = '0;
						if (code_x == roots + (CODE_W+1)'(1)) begin
							end_d = 1'b1;
						end else if (code_x == roots) begin
							nfc_d = roots + (CODE_W+1)'(2);
							cw_d = rs_q + 4'd1;
							fac_d = 1'b1;
							prev_d = '0;
						end else if (fac_q) begin
							if (code_x >= roots) begin
								err_d = 1'b1;
							end else begin
								fac_d = 1'b0;
								wptr_d = slot(code); woff_d = CODE_W'(1); wact_d = 1'b1;
								prev_d = code; prev_len_d = CODE_W'(1);
								prev_first_d = code[7:0];
							end
						end else if (code_x < nfc_q) begin
							op_d = OP_KNOWN;
							tbl_re = 1'b1;
							tbl_raddr = slot(code);
						end else if (code_x == nfc_q && nfc_q < DEPTH_C) begin
							// Code not yet in the table: it is the previous string
							// plus its own first symbol.
							ae_do = 1'b1;
							wptr_d = code; woff_d = ae_len; wact_d = 1'b1;
							prev_d = code; prev_len_d = ae_len;
						end else begin
							err_d = 1'b1;
						end
					end
				end
			end
		end else if (busy_s1) begin
			case (op_s1)
				OP_WALK: begin
					pv_d = 1'b1;
					color_d = rd.last;
					pnum_d = pcnt_q + 32'(rd.length) - 32'd1;
					if (rd.length <= CODE_W'(1)) begin
						wact_d = 1'b0;
						pcnt_d = pcnt_q + 32'(woff_q);
					end else begin
						wptr_d = slot(rd.parent);
					end
				end
				OP_KNOWN: begin
					ae_do = 1'b1;
					ae_last = rd.first;
					wptr_d = slot(code_s1); woff_d = rd.length; wact_d = 1'b1;
					prev_d = code_s1; prev_len_d = rd.length; prev_first_d = rd.first;
				end
				default: begin
				end
			endcase
			need_d = pull_s1 && left_q == 4'd0 && !wact_d && !end_q && !err_q;
		end

		tbl_we = ae_do && nfc_q < DEPTH_C;
		tbl_wdata = '{parent: ae_parent, length: ae_len, first: ae_first, last: ae_last};
		cw_limit = ((CODE_W+1)'(1) << cw_q) - (CODE_W+1)'(1);
		if (tbl_we) begin
			nfc_d = nfc_q + (CODE_W+1)'(1);
			if (nfc_q == cw_limit && cw_q < MCW_C) begin
				cw_d = cw_q + 4'd1;
			end
		end

		if (cfg_we) begin
			rs_d = rs_new;
			acc_d = '0; gath_d = '0; cw_d = rs_new + 4'd1;
			nfc_d = ((CODE_W+1)'(1) << rs_new) + (CODE_W+1)'(2);
			prev_d = '0; fac_d = 1'b1; held_d = '0; left_d = '0;
			wptr_d = '0; woff_d = '0; wact_d = 1'b0; pcnt_d = '0;
			end_d = 1'b0; err_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rs_q <= ROOT_SIZE_RST;
			acc_q <= '0; gath_q <= '0; cw_q <= ROOT_SIZE_RST + 4'd1;
			nfc_q <= ((CODE_W+1)'(1) << ROOT_SIZE_RST) + (CODE_W+1)'(2);
			prev_q <= '0; prev_len_q <= '0; prev_first_q <= '0; fac_q <= 1'b1;
			held_q <= '0; left_q <= '0; wptr_q <= '0; woff_q <= '0; wact_q <= 1'b0;
			pcnt_q <= '0; end_q <= 1'b0; err_q <= 1'b0;
			busy_s1 <= 1'b0; op_s1 <= OP_NONE; pull_s1 <= 1'b0; code_s1 <= '0;
			res_valid_q <= 1'b0;
		end else begin
			rs_q <= rs_d; acc_q <= acc_d; gath_q <= gath_d; cw_q <= cw_d; nfc_q <= nfc_d;
			prev_q <= prev_d; prev_len_q <= prev_len_d; prev_first_q <= prev_first_d;
			fac_q <= fac_d; held_q <= held_d; left_q <= left_d; wptr_q <= wptr_d;
			woff_q <= woff_d; wact_q <= wact_d; pcnt_q <= pcnt_d;
			end_q <= end_d; err_q <= err_d;
			busy_s1 <= acc_ok;
			if (acc_ok) begin
				op_s1 <= op_d;
				pull_s1 <= pull_d;
				code_s1 <= code;
			end
			if (busy_s1) begin
				res_valid_q <= 1'b1;
			end else if (res_ch.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_s1) begin
			pv_q <= pv_d;
			color_q <= color_d;
			pnum_q <= pnum_d;
			need_q <= need_d;
		end
	end

	assign res_ch.valid = res_valid_q;
	assign res_ch.pixel_valid = pv_q;
	assign res_ch.color_index = color_q;
	assign res_ch.pixel_number = pnum_q;
	assign res_ch.need_byte = need_q;
	assign res_ch.end_of_image = end_q;
	assign res_ch.decode_error = err_q;

	`GLD_ASSERT(a_accept_starts_s1, acc_ok |=> busy_s1, "transfer did not enter second cycle")
	`GLD_ASSERT(a_s1_one_cycle, busy_s1 |=> !busy_s1, "second cycle held longer than one")
	`GLD_ASSERT(a_result_after_s1, $rose(res_ch.valid) |-> $past(busy_s1), "result without work")
	`GLD_ASSERT(a_port_exclusive, !(tbl_we && tbl_re), "table read and write in one cycle")

endmodule

FILE: sim/gif_lzw_decoder_core_test.sv
// Self-checking testbench of gif_lzw_decoder_core: random LZW code streams
// are packed into bytes and checked against a scoreboard that decodes them.
// Depends on gld_pkg (rtl/gld_pkg.sv) and the channel interfaces in rtl/gld_if.sv.
module gif_lzw_decoder_core_test;
	import gld_pkg::*;

	localparam int DEPTH = TABLE_DEPTH_DEF;
	localparam int MAXW  = MAX_CODE_WIDTH_DEF;
	localparam bit REQ_PUSH = 1'b0;
	localparam bit REQ_PULL = 1'b1;

	typedef struct packed {
		logic        pix;
		logic [7:0]  color;
		logic [31:0] num;
		logic        need;
		logic        eoi;
		logic        err;
	} pixel_res_t;

	class lzw_scoreboard;
		logic [11:0] parent_of[DEPTH];
		logic [11:0] length_of[DEPTH];
		logic [7:0]  first_of[DEPTH];
		logic [7:0]  last_of[DEPTH];
		int unsigned root_size, acc, gathered, width, next_code, prev_code;
		int unsigned held, held_left, walk_ptr, walk_len, pixel_base;
		bit fresh, walking, ended, errored;
		pixel_res_t pending[$];
		int mismatches, results_seen, pixels_seen;

		function void set_root_size(logic [3:0] v);
			int unsigned r;
			r = v;
			if (r < 2) r = 2;
			if (r > 11) r = 11;
			while (r > 2 && (r + 1 > MAXW || (1 << r) + 2 > DEPTH)) r--;
			root_size = r;
			for (int i = 0; i < DEPTH; i++) begin
				parent_of[i] = '0;
				length_of[i] = (i < (1 << r)) ? 12'd1 : 12'd0;
				first_of[i] = (i < (1 << r)) ? i[7:0] : 8'd0;
				last_of[i] = first_of[i];
			end
			acc = 0; gathered = 0; width = r + 1; next_code = (1 << r) + 2;
			prev_code = 0; fresh = 1; held = 0; held_left = 0;
			walk_ptr = 0; walk_len = 0; walking = 0; pixel_base = 0;
			ended = 0; errored = 0;
		endfunction

		function int unsigned bound(int unsigned i);
			return (i < DEPTH) ? i : 0;
		endfunction

		function void begin_string(int unsigned c);
			walk_ptr = bound(c);
			walk_len = length_of[walk_ptr];
			walking = 1;
		endfunction

		function void grow_table(int unsigned p_in, logic [7:0] val);
			int unsigned p;
			p = bound(p_in);
			if (next_code >= DEPTH) return;
			parent_of[next_code] = p[11:0];
			length_of[next_code] = length_of[p] + 12'd1;
			first_of[next_code] = first_of[p];
			last_of[next_code] = val;
			if (next_code == (1 << width) - 1 && width < MAXW) width++;
			next_code++;
		endfunction

		function void apply_code(int unsigned c);
			int unsigned roots;
			roots = 1 << root_size;
			if (c == roots + 1) begin
				ended = 1;
				return;
			end
			if (c == roots) begin
				next_code = roots + 2; width = root_size + 1; fresh = 1; prev_code = 0;
				return;
			end
			if (fresh) begin
				if (c >= roots) begin
					errored = 1;
					return;
				end
				fresh = 0;
				begin_string(c);
				prev_code = c;
				return;
			end
			if (c < next_code) begin
				begin_string(c);
				grow_table(prev_code, first_of[bound(c)]);
			end else if (c == next_code && next_code < DEPTH) begin
				grow_table(prev_code, first_of[bound(prev_code)]);
				begin_string(c);
			end else begin
				errored = 1;
				return;
			end
			prev_code = c;
		endfunction

		function pixel_res_t decode_step(bit rt, logic [7:0] b);
			pixel_res_t r;
			int unsigned node, len, n, c;
			r = '0;
			if (!ended && !errored) begin
				if (rt == REQ_PUSH) begin
					held = b; held_left = 8;
				end else if (walking) begin
					node = bound(walk_ptr);
					len = length_of[node];
					r.pix = 1;
					r.color = last_of[node];
					r.num = pixel_base + len - 1;
					if (len <= 1) begin
						walking = 0;
						pixel_base += walk_len;
					end else begin
						walk_ptr = bound(parent_of[node]);
					end
				end else if (held_left != 0) begin
					n = (held_left < width - gathered) ? held_left : width - gathered;
					acc = (acc | ((held & ((1 << n) - 1)) << gathered)) & 12'hFFF;
					held = (held >> n) & 8'hFF;
					held_left -= n;
					gathered += n;
					if (gathered >= width) begin
						c = acc; acc = 0; gathered = 0;
						apply_code(c);
					end
				end
				r.need = (rt == REQ_PULL) && held_left == 0 && !walking && !ended && !errored;
			end
			r.eoi = ended;
			r.err = errored;
			return r;
		endfunction

		function void note_request(bit rt, logic [7:0] b);
			pending.push_back(decode_step(rt, b));
		endfunction

		function void check_result(pixel_res_t got);
			pixel_res_t want;
			results_seen++;
			if (got.pix === 1'b1) pixels_seen++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("Unexpected result transfer: %p", got);
				return;
			end
			want = pending.pop_front();
			if (got.pix !== want.pix || got.color !== want.color || got.num !== want.num ||
					got.need !== want.need || got.eoi !== want.eoi || got.err !== want.err) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Result mismatch: expected %p, got %p", want, got);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [3:0] cfg_wdata = '0;
	gld_req_if req_ch();
	gld_res_if res_ch();

	gif_lzw_decoder_core i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.req_ch(req_ch.sink), .res_ch(res_ch.source)
	);

	lzw_scoreboard sb = new();
	bit hold_request = 0;
	int items_sent = 0, phases_run = 0;

	// Encoder-side view of the table, used to choose legal codes.
	int unsigned enc_next, enc_width;
	bit enc_fresh;
	bit code_bits[$];

	always #5 clk = ~clk;

	initial begin
		req_ch.valid = 0;
		req_ch.req_type = REQ_PUSH;
		req_ch.data_byte = '0;
	end

	task automatic send_request(bit rt, logic [7:0] b);
		int r, gap;
		req_ch.valid <= 1;
		req_ch.req_type <= rt;
		req_ch.data_byte <= b;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		sb.note_request(rt, b);
		items_sent++;
		@(negedge clk);
		r = $urandom_range(99);
		gap = (r < 60) ? 0 : (r < 92) ? $urandom_range(3, 1) : $urandom_range(40, 10);
		if (gap > 0) begin
			req_ch.valid <= 0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic wait_drained();
		req_ch.valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_root_size(logic [3:0] v);
		wait_drained();
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		sb.set_root_size(v);
		@(negedge clk);
		cfg_we <= 0;
	endtask

	task automatic queue_code(int unsigned c);
		for (int i = 0; i < enc_width; i++) code_bits.push_back(c[i]);
	endtask

	// Picks the next code the way a well-formed stream would; with bad_start the
	// first code after clear is a non-root code.
	task automatic emit_code(bit bad_start);
		int unsigned roots, c, r;
		roots = 1 << sb.root_size;
		r = $urandom_range(99);
		if (enc_fresh) begin
			c = bad_start ? roots + 2 : $urandom_range(roots - 1);
			queue_code(c);
			enc_fresh = 0;
			return;
		end
		if (r < 3) begin
			queue_code(roots);
			enc_next = roots + 2; enc_width = sb.root_size + 1; enc_fresh = 1;
			return;
		end
		if (r < 50) c = $urandom_range(roots - 1);
		else if (r < 60 && enc_next < DEPTH) c = enc_next;
		else c = $urandom_range((enc_next < DEPTH) ? enc_next : DEPTH - 1, roots + 2);
		queue_code(c);
		if (enc_next < DEPTH) begin
			if (enc_next == (1 << enc_width) - 1 && enc_width < MAXW) enc_width++;
			enc_next++;
		end
	endtask

	// One image: n_codes codes then the end code. Noise pushes stray bytes.
	task automatic run_image(int n_codes, bit bad_start, bit noisy);
		int emitted;
		logic [7:0] b;
		enc_next = (1 << sb.root_size) + 2;
		enc_width = sb.root_size + 1;
		enc_fresh = 1;
		code_bits.delete();
		emitted = 0;
		phases_run++;
		while (!sb.ended && !sb.errored) begin
			while (code_bits.size() < 8 && emitted <= n_codes) begin
				if (emitted == n_codes) begin
					queue_code((1 << sb.root_size) + 1);
					while (code_bits.size() % 8 != 0) code_bits.push_back(1'($urandom_range(1)));
				end else begin
					emit_code(bad_start);
				end
				emitted++;
			end
			if (noisy && $urandom_range(99) < 4) begin
				send_request(REQ_PUSH, 8'($urandom_range(255)));
			end else if (sb.held_left == 0 && !sb.walking && $urandom_range(99) >= 5) begin
				for (int i = 0; i < 8; i++)
					b[i] = (code_bits.size() != 0) ? code_bits.pop_front() :
						1'($urandom_range(1));
				send_request(REQ_PUSH, b);
			end else begin
				send_request(REQ_PULL, 8'($urandom_range(255)));
			end
			if (items_sent == 300) hold_request = 1;
		end
		// Requests after the end or an error must change nothing.
		send_request(REQ_PULL, 8'hFF);
		send_request(REQ_PUSH, 8'h00);
	endtask

	initial begin
		int unsigned sizes[$] = '{4'd2, 4'd11, 4'd0, 4'd15, 4'd1, 4'd12, 4'd5};
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		sb.set_root_size(ROOT_SIZE_RST);
		run_image(12, 0, 0);
		write_root_size(4'd2);
		run_image(8, 0, 0);
		write_root_size(4'd3);
		run_image(2, 1, 0);
		foreach (sizes[i]) begin
			write_root_size(4'(sizes[i]));
			run_image($urandom_range(24, 6), 0, i % 3 == 2);
		end
		while (items_sent < 800) begin
			write_root_size(4'($urandom_range(15)));
			run_image($urandom_range(50, 5), 0, $urandom_range(4) == 0);
		end
		req_ch.valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("Sent %0d requests over %0d images; checked %0d results, %0d of them pixels.",
			items_sent, phases_run, sb.results_seen, sb.pixels_seen);
		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("%0d mismatching result transfers, %0d results missing.",
				sb.mismatches, sb.pending.size());
			$display("Mismatches found");
		end
		$finish;
	end

	// Result side: random stalls, plus one long hold-off on request.
	initial begin
		int low_left;
		low_left = 0;
		res_ch.ready = 0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 0;
				low_left = 300;
			end
			if (low_left > 0) begin
				res_ch.ready <= 0;
				low_left--;
			end else if ($urandom_range(99) < 70) begin
				res_ch.ready <= 1;
			end else begin
				res_ch.ready <= 0;
				low_left = ($urandom_range(99) < 90) ? $urandom_range(2) : $urandom_range(30, 10);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
			sb.check_result({res_ch.pixel_valid, res_ch.color_index, res_ch.pixel_number,
				res_ch.need_byte, res_ch.end_of_image, res_ch.decode_error});
	end

	initial begin
		#5000000;
		$display("Mismatches found");
		$finish;
	end

endmodule

FILE: gif_lzw_decoder_core.f
+incdir+rtl
rtl/gld_pkg.sv
rtl/gld_if.sv
rtl/gld_unpack.sv
rtl/gld_table.sv
rtl/gld_lzw_decoder_core.sv
sim/gif_lzw_decoder_core_test.sv
